/* hdl/tpbb_pkg.sv */
// ----------------------------------------------------------------------------
// tpbb_pkg: shared types and constants of the transformed point bounding box
// Operand widths of the shared multiplier, sequencer tags and the
// configuration bundle used by the register file and the core.
// ----------------------------------------------------------------------------
package tpbb_pkg;

    // Default fraction width of vertex coordinates.
    localparam int FRAC_BITS_DEF = 16;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 35;
    localparam int PROD_W = 2 * MUL_W;

    // Quotient width of 2^61 / n with n >= 2^28.
    localparam int QUOT_W = 34;

    // Kinds of multiplier work, carried with each beat through the unit.
    localparam logic [1:0] KIND_QUAT = 2'd0;
    localparam logic [1:0] KIND_MAT  = 2'd1;
    localparam logic [1:0] KIND_VTX  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_POS_X  = 3'd0;
    localparam logic [2:0] REG_POS_Y  = 3'd1;
    localparam logic [2:0] REG_POS_Z  = 3'd2;
    localparam logic [2:0] REG_QUAT_W = 3'd3;
    localparam logic [2:0] REG_QUAT_X = 3'd4;
    localparam logic [2:0] REG_QUAT_Y = 3'd5;
    localparam logic [2:0] REG_QUAT_Z = 3'd6;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] idx;
    } mul_tag_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
    } cfg_t;

    // Row of a matrix element index.
    function automatic logic [1:0] row_of(input logic [3:0] idx);
        logic [1:0] r;
        case (idx)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // Column of a matrix element index.
    function automatic logic [1:0] col_of(input logic [3:0] idx);
        logic [1:0] c;
        case (idx)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

/* hdl/tpbb_regs.sv */
// ----------------------------------------------------------------------------
// tpbb_regs: configuration register file
// APB-style slave holding the translation and the orientation quaternion.
// ----------------------------------------------------------------------------
module tpbb_regs
    import tpbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t        cfg_reg;
    logic [2:0]  index;
    logic        wr_en;

    assign pready = 1'b1;
    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes on the access beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x  <= '0;
            cfg_reg.pos_y  <= '0;
            cfg_reg.pos_z  <= '0;
            cfg_reg.quat_w <= ONE_Q30;
            cfg_reg.quat_x <= '0;
            cfg_reg.quat_y <= '0;
            cfg_reg.quat_z <= '0;
        end
        else if (wr_en)
        begin
            case (index)
                REG_POS_X:  cfg_reg.pos_x  <= pwdata;
                REG_POS_Y:  cfg_reg.pos_y  <= pwdata;
                REG_POS_Z:  cfg_reg.pos_z  <= pwdata;
                REG_QUAT_W: cfg_reg.quat_w <= pwdata;
                REG_QUAT_X: cfg_reg.quat_x <= pwdata;
                REG_QUAT_Y: cfg_reg.quat_y <= pwdata;
                REG_QUAT_Z: cfg_reg.quat_z <= pwdata;
                default:    ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (index)
            REG_POS_X:  prdata = cfg_reg.pos_x;
            REG_POS_Y:  prdata = cfg_reg.pos_y;
            REG_POS_Z:  prdata = cfg_reg.pos_z;
            REG_QUAT_W: prdata = cfg_reg.quat_w;
            REG_QUAT_X: prdata = cfg_reg.quat_x;
            REG_QUAT_Y: prdata = cfg_reg.quat_y;
            REG_QUAT_Z: prdata = cfg_reg.quat_z;
            default:    prdata = '0;
        endcase
    end

endmodule

/* hdl/tpbb_mul.sv */
// ----------------------------------------------------------------------------
// tpbb_mul: shared signed multiplier
// One product per cycle with a registered result; a tag travels alongside.
// ----------------------------------------------------------------------------
module tpbb_mul
    import tpbb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  mul_tag_t                 in_tag,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic                     out_valid,
    output mul_tag_t                 out_tag,
    output logic signed [PROD_W-1:0] p
);

    logic                     valid_reg;
    mul_tag_t                 tag_reg;
    logic signed [PROD_W-1:0] p_reg;

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign p         = p_reg;

    // Valid flag of the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Product and tag register.
    always_ff @(posedge clk)
    begin
        tag_reg <= in_tag;
        p_reg   <= a * b;
    end

endmodule

/* hdl/tpbb_div.sv */
// ----------------------------------------------------------------------------
// tpbb_div: radix-2 restoring divider for 2^61 / n
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpbb_div
    import tpbb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       den,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    localparam logic [5:0] TOP_BIT = 6'd61;

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        bit_reg;
    logic [32:0]       rem_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [31:0]       den_reg;
    logic [33:0]       trial;
    logic              fits;

    assign trial = {rem_reg, (bit_reg == TOP_BIT)};
    assign fits  = (trial >= {2'b00, den_reg});
    assign done  = done_reg;
    assign quot  = quot_reg;

    // Control: count down through the dividend bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= TOP_BIT;
            end
            else if (busy_reg)
            begin
                if (bit_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    bit_reg <= bit_reg - 6'd1;
                end
            end
        end
    end

    // Datapath: one shift, compare and subtract per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= 33'(trial - {2'b00, den_reg});
            else
                rem_reg <= trial[32:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

endmodule

/* hdl/transformed_point_bounding_box_core.sv */
// ----------------------------------------------------------------------------
// transformed_point_bounding_box_core: bounding box of a rotated shape
// Rotates each vertex by a quaternion, adds a translation and keeps the
// per-axis extent; the marked vertex releases the box with a margin.
//
//   Channel   Dir  Content
//   s_axis    in   tdata = vertex x,y,z; tlast = last vertex of the shape
//   m_axis    out  tdata = upper x,y,z, lower x,y,z; tuser = clipped, bad_rotation
//   APB       in   pos_x/y/z at 0x00..0x08, quat_w/x/y/z at 0x0C..0x18
//
// A vertex passes nine products through the shared multiplier, then the
// result stage, the rounding stage and the update.
// The first vertex of a run also builds the matrix: quaternion scaling,
// ten products, the division and the nine matrix entries, in that order.
// Reset leaves the block idle with empty bounds; no clearing pass.
// A finished box waits in the output register; only the next box stalls.
// ----------------------------------------------------------------------------
module transformed_point_bounding_box_core
    import tpbb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Vertex stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic         s_axis_tlast,   // last_vertex
    // Box stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // upper_x/y/z, lower_x/y/z
    output logic [1:0]   m_axis_tuser,   // clipped, bad_rotation
    // Configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic signed [32:0] MARGIN = 33'sd0 + 33'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic signed [32:0] S32_MAX = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0] S32_MIN = -33'sh0_8000_0000;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_NORM  = 4'd1;
    localparam logic [3:0] ST_PROD  = 4'd2;
    localparam logic [3:0] ST_PWAIT = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_MAT   = 4'd5;
    localparam logic [3:0] ST_MWAIT = 4'd6;
    localparam logic [3:0] ST_VTX   = 4'd7;
    localparam logic [3:0] ST_VWAIT = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    cfg_t cfg;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic [3:0]  issue_reg;
    logic        run_started_reg;
    logic        clip_seen_reg;
    logic        bad_seen_reg;
    logic        last_reg;
    logic        div_start_reg;
    logic        fin_valid_reg;
    logic [1:0]  fin_axis_reg;

    logic signed [31:0] vtx_reg [3];
    logic signed [32:0] q_reg [4];
    logic signed [31:0] prod_reg [10];
    logic signed [31:0] rot_reg [9];
    logic signed [31:0] upper_reg [3];
    logic signed [31:0] lower_reg [3];
    logic signed [66:0] acc_reg;
    logic [QUOT_W-1:0]  s_reg;

    logic               m_valid_reg;
    logic [191:0]       m_data_reg;
    logic [1:0]         m_user_reg;

    // Multiplier and divider hookup.
    logic                     mul_in_valid;
    mul_tag_t                 mul_in_tag;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic                     mul_out_valid;
    mul_tag_t                 mul_out_tag;
    logic signed [PROD_W-1:0] mul_p;
    logic                     div_done;
    logic [QUOT_W-1:0]        div_quot;
    logic [31:0]              norm_sum;

    // Quaternion scaling helpers.
    logic [32:0]        q_abs [4];
    logic [32:0]        q_max;
    logic               q_big;
    logic               q_small;
    logic               q_zero;

    // Matrix entry term and result arithmetic.
    logic signed [32:0]       mat_term;
    logic signed [PROD_W-1:0] p_shift;
    logic signed [41:0]       ent_raw;
    logic signed [31:0]       ent_sat;

    // Vertex rounding stage.
    logic signed [36:0] rnd;
    logic signed [37:0] coord_raw;
    logic signed [31:0] coord;
    logic               coord_clip;
    logic signed [31:0] pos_sel;

    // Bounds with margin.
    logic signed [32:0] up_raw [3];
    logic signed [32:0] lo_raw [3];
    logic signed [31:0] up_sat [3];
    logic signed [31:0] lo_sat [3];
    logic               clip_now;

    tpbb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpbb_mul u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_in_valid),
        .in_tag    (mul_in_tag),
        .a         (mul_a),
        .b         (mul_b),
        .out_valid (mul_out_valid),
        .out_tag   (mul_out_tag),
        .p         (mul_p)
    );

    assign norm_sum = 32'(prod_reg[0]) + 32'(prod_reg[1]) + 32'(prod_reg[2]) + 32'(prod_reg[3]);

    tpbb_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .den   (norm_sum),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Largest quaternion part magnitude.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            q_abs[i] = q_reg[i][32] ? 33'(-q_reg[i]) : 33'(q_reg[i]);
        q_max = q_abs[0];
        for (int i = 1; i < 4; i++)
            if (q_abs[i] > q_max)
                q_max = q_abs[i];
        q_big   = (q_max >= 33'h0_4000_0000);
        q_small = (q_max < 33'h0_2000_0000);
    end

    assign q_zero = (cfg.quat_w == 0) && (cfg.quat_x == 0) &&
                    (cfg.quat_y == 0) && (cfg.quat_z == 0);

    // Term that scales each matrix entry.
    always_comb
    begin
        case (issue_reg)
            4'd0:    mat_term = 33'(prod_reg[2]) + 33'(prod_reg[3]);
            4'd1:    mat_term = 33'(prod_reg[4]) - 33'(prod_reg[9]);
            4'd2:    mat_term = 33'(prod_reg[5]) + 33'(prod_reg[8]);
            4'd3:    mat_term = 33'(prod_reg[4]) + 33'(prod_reg[9]);
            4'd4:    mat_term = 33'(prod_reg[1]) + 33'(prod_reg[3]);
            4'd5:    mat_term = 33'(prod_reg[6]) - 33'(prod_reg[7]);
            4'd6:    mat_term = 33'(prod_reg[5]) - 33'(prod_reg[8]);
            4'd7:    mat_term = 33'(prod_reg[6]) + 33'(prod_reg[7]);
            default: mat_term = 33'(prod_reg[1]) + 33'(prod_reg[2]);
        endcase
    end

    // Multiplier operand select under the sequencer.
    always_comb
    begin
        mul_in_valid    = 1'b0;
        mul_in_tag.kind = KIND_QUAT;
        mul_in_tag.idx  = issue_reg;
        mul_a           = '0;
        mul_b           = '0;
        case (state_reg)
            ST_PROD:
            begin
                mul_in_valid = 1'b1;
                case (issue_reg)
                    4'd0:    begin mul_a = MUL_W'(q_reg[0]); mul_b = MUL_W'(q_reg[0]); end
                    4'd1:    begin mul_a = MUL_W'(q_reg[1]); mul_b = MUL_W'(q_reg[1]); end
                    4'd2:    begin mul_a = MUL_W'(q_reg[2]); mul_b = MUL_W'(q_reg[2]); end
                    4'd3:    begin mul_a = MUL_W'(q_reg[3]); mul_b = MUL_W'(q_reg[3]); end
                    4'd4:    begin mul_a = MUL_W'(q_reg[1]); mul_b = MUL_W'(q_reg[2]); end
                    4'd5:    begin mul_a = MUL_W'(q_reg[1]); mul_b = MUL_W'(q_reg[3]); end
                    4'd6:    begin mul_a = MUL_W'(q_reg[2]); mul_b = MUL_W'(q_reg[3]); end
                    4'd7:    begin mul_a = MUL_W'(q_reg[0]); mul_b = MUL_W'(q_reg[1]); end
                    4'd8:    begin mul_a = MUL_W'(q_reg[0]); mul_b = MUL_W'(q_reg[2]); end
                    default: begin mul_a = MUL_W'(q_reg[0]); mul_b = MUL_W'(q_reg[3]); end
                endcase
            end
            ST_MAT:
            begin
                mul_in_valid    = 1'b1;
                mul_in_tag.kind = KIND_MAT;
                mul_a           = $signed({1'b0, s_reg});
                mul_b           = MUL_W'(mat_term);
            end
            ST_VTX:
            begin
                mul_in_valid    = 1'b1;
                mul_in_tag.kind = KIND_VTX;
                mul_a           = MUL_W'(rot_reg[issue_reg]);
                mul_b           = MUL_W'(vtx_reg[col_of(issue_reg)]);
            end
            default: ;
        endcase
    end

    // Matrix entry from a scaled product: floor, diagonal offset, clamp.
    always_comb
    begin
        p_shift = mul_p >>> 30;
        if (mul_out_tag.idx == 4'd0 || mul_out_tag.idx == 4'd4 || mul_out_tag.idx == 4'd8)
            ent_raw = 42'(ONE_Q30) - p_shift[41:0];
        else
            ent_raw = p_shift[41:0];
        if (ent_raw > 42'(S32_MAX))
            ent_sat = S32_MAX[31:0];
        else if (ent_raw < 42'(S32_MIN))
            ent_sat = S32_MIN[31:0];
        else
            ent_sat = ent_raw[31:0];
    end

    // Rounding, translation and saturation of one moved coordinate.
    always_comb
    begin
        case (fin_axis_reg)
            2'd0:    pos_sel = cfg.pos_x;
            2'd1:    pos_sel = cfg.pos_y;
            default: pos_sel = cfg.pos_z;
        endcase
        rnd        = 37'((acc_reg + 67'sh2000_0000) >>> 30);
        coord_raw  = 38'(rnd) + 38'(pos_sel);
        coord_clip = 1'b0;
        if (coord_raw > 38'(S32_MAX))
        begin
            coord      = S32_MAX[31:0];
            coord_clip = 1'b1;
        end
        else if (coord_raw < 38'(S32_MIN))
        begin
            coord      = S32_MIN[31:0];
            coord_clip = 1'b1;
        end
        else
        begin
            coord = coord_raw[31:0];
        end
    end

    // Bounds with margin for the released box.
    always_comb
    begin
        clip_now = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            up_raw[i] = 33'(upper_reg[i]) + MARGIN;
            lo_raw[i] = 33'(lower_reg[i]) - MARGIN;
            if (up_raw[i] > S32_MAX)
            begin
                up_sat[i] = S32_MAX[31:0];
                clip_now  = 1'b1;
            end
            else
            begin
                up_sat[i] = up_raw[i][31:0];
            end
            if (lo_raw[i] < S32_MIN)
            begin
                lo_sat[i] = S32_MIN[31:0];
                clip_now  = 1'b1;
            end
            else
            begin
                lo_sat[i] = lo_raw[i][31:0];
            end
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (run_started_reg || q_zero)
                        state_next = ST_VTX;
                    else
                        state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (!q_big && !q_small)
                    state_next = ST_PROD;
            end
            ST_PROD:
            begin
                if (issue_reg == 4'd9)
                    state_next = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                if (mul_out_valid)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_MAT;
            end
            ST_MAT:
            begin
                if (issue_reg == 4'd8)
                    state_next = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (mul_out_valid)
                    state_next = ST_VTX;
            end
            ST_VTX:
            begin
                if (issue_reg == 4'd8)
                    state_next = ST_VWAIT;
            end
            ST_VWAIT:
            begin
                if (fin_valid_reg && fin_axis_reg == 2'd2)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!last_reg || !m_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            issue_reg       <= '0;
            run_started_reg <= 1'b0;
            clip_seen_reg   <= 1'b0;
            bad_seen_reg    <= 1'b0;
            div_start_reg   <= 1'b0;
            fin_valid_reg   <= 1'b0;
            fin_axis_reg    <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                upper_reg[i] <= S32_MIN[31:0];
                lower_reg[i] <= S32_MAX[31:0];
            end
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= (state_reg == ST_PWAIT) && mul_out_valid;

            // Issue counter runs in the issuing states only.
            if ((state_reg == ST_PROD || state_reg == ST_MAT || state_reg == ST_VTX) &&
                state_next == state_reg)
                issue_reg <= issue_reg + 4'd1;
            else
                issue_reg <= '0;

            // Start of a run: matrix build begins unless the quaternion is zero, which is flagged.
            if (state_reg == ST_IDLE && s_axis_tvalid && !run_started_reg)
            begin
                run_started_reg <= 1'b1;
                bad_seen_reg    <= q_zero;
            end

            // Vertex accumulation finishes one axis.
            fin_valid_reg <= mul_out_valid && (mul_out_tag.kind == KIND_VTX) &&
                             (col_of(mul_out_tag.idx) == 2'd2);
            fin_axis_reg  <= row_of(mul_out_tag.idx);

            // Running extent update.
            if (fin_valid_reg)
            begin
                if (coord_clip)
                    clip_seen_reg <= 1'b1;
                if (coord > upper_reg[fin_axis_reg])
                    upper_reg[fin_axis_reg] <= coord;
                if (coord < lower_reg[fin_axis_reg])
                    lower_reg[fin_axis_reg] <= coord;
            end

            // Output handshake.
            if (state_reg == ST_OUT && last_reg && (!m_valid_reg || m_axis_tready))
            begin
                m_valid_reg     <= 1'b1;
                run_started_reg <= 1'b0;
                clip_seen_reg   <= 1'b0;
                bad_seen_reg    <= 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    upper_reg[i] <= S32_MIN[31:0];
                    lower_reg[i] <= S32_MAX[31:0];
                end
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        // Capture the vertex beat and the quaternion with every accepted beat.
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            vtx_reg[0] <= s_axis_tdata[31:0];
            vtx_reg[1] <= s_axis_tdata[63:32];
            vtx_reg[2] <= s_axis_tdata[95:64];
            last_reg   <= s_axis_tlast;
            q_reg[0]   <= 33'(cfg.quat_w);
            q_reg[1]   <= 33'(cfg.quat_x);
            q_reg[2]   <= 33'(cfg.quat_y);
            q_reg[3]   <= 33'(cfg.quat_z);
            if (!run_started_reg && q_zero)
            begin
                for (int i = 0; i < 9; i++)
                    rot_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q30 : 32'sd0;
            end
        end

        // One scaling step by a power of two.
        if (state_reg == ST_NORM)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (q_big)
                    q_reg[i] <= q_reg[i] >>> 1;
                else if (q_small)
                    q_reg[i] <= q_reg[i] <<< 1;
            end
        end

        if (div_done)
            s_reg <= div_quot;

        // Multiplier results by kind.
        if (mul_out_valid)
        begin
            case (mul_out_tag.kind)
                KIND_QUAT: prod_reg[mul_out_tag.idx] <= p_shift[31:0];
                KIND_MAT:  rot_reg[mul_out_tag.idx]  <= ent_sat;
                KIND_VTX:
                begin
                    if (col_of(mul_out_tag.idx) == 2'd0)
                        acc_reg <= 67'(mul_p);
                    else
                        acc_reg <= acc_reg + 67'(mul_p);
                end
                default: ;
            endcase
        end

        // Released box.
        if (state_reg == ST_OUT && last_reg && (!m_valid_reg || m_axis_tready))
        begin
            m_data_reg <= {lo_sat[2], lo_sat[1], lo_sat[0], up_sat[2], up_sat[1], up_sat[0]};
            m_user_reg <= {bad_seen_reg, clip_seen_reg || clip_now};
        end
    end

endmodule

/* bench/transformed_point_bounding_box_core_test.sv */
// ----------------------------------------------------------------------------
// Bounding box core testbench
// Streams runs of vertices through the core under several stall patterns and
// configurations, predicts each box with an independent fixed-point model and
// compares every box beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module transformed_point_bounding_box_core_test
    import tpbb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MARGIN   = ((1 << FRAC_BITS_DEF) + 5) / 10;
    localparam int IDLE_MAX = 20000;

    typedef struct {
        logic [31:0] upper [3];
        logic [31:0] lower [3];
        logic        clipped;
        logic        bad_rotation;
    } box_t;

    // Box predictor and store of predicted boxes.
    class box_scoreboard;
        longint pos [3];
        longint quat [4];
        logic signed [95:0] mat [9];
        logic signed [95:0] run_upper [3];
        logic signed [95:0] run_lower [3];
        bit started, clip_seen, bad_seen;
        box_t pending [$];
        int errors;

        function new();
            pos = '{0, 0, 0};
            quat = '{longint'(ONE_Q30), 0, 0, 0};
            errors = 0;
            clear_run();
        endfunction

        function void clear_run();
            for (int i = 0; i < 3; i++)
            begin
                run_upper[i] = -96'sd2147483648;
                run_lower[i] = 96'sd2147483647;
            end
            started = 0;
            clip_seen = 0;
            bad_seen = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] value);
            if (idx < 3)
                pos[idx] = longint'(signed'(value));
            else
                quat[idx - 3] = longint'(signed'(value));
        endfunction

        function logic signed [95:0] clamp(logic signed [95:0] v, ref bit hit);
            if (v > 96'sd2147483647)
            begin
                hit = 1;
                return 96'sd2147483647;
            end
            if (v < -96'sd2147483648)
            begin
                hit = 1;
                return -96'sd2147483648;
            end
            return v;
        endfunction

        // Quaternion to rotation matrix, normalized by one division.
        function void build_rotation();
            longint q [4];
            longint mx, w, x, y, z, ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, n, s;
            longint e [9];
            bit unused_hit;
            q = quat;
            mx = 0;
            bad_seen = 0;
            for (int i = 0; i < 4; i++)
                if ((q[i] < 0 ? -q[i] : q[i]) > mx)
                    mx = q[i] < 0 ? -q[i] : q[i];
            if (mx == 0)
            begin
                foreach (mat[i])
                    mat[i] = (i % 4 == 0) ? 96'sd1073741824 : 96'sd0;
                bad_seen = 1;
                return;
            end
            while (mx >= (64'sd1 <<< 30))
            begin
                mx = 0;
                for (int i = 0; i < 4; i++)
                begin
                    q[i] = q[i] >>> 1;
                    if ((q[i] < 0 ? -q[i] : q[i]) > mx)
                        mx = q[i] < 0 ? -q[i] : q[i];
                end
            end
            while (mx < (64'sd1 <<< 29))
            begin
                for (int i = 0; i < 4; i++)
                    q[i] = q[i] * 2;
                mx = mx * 2;
            end
            w = q[0]; x = q[1]; y = q[2]; z = q[3];
            ww = (w * w) >>> 30; xx = (x * x) >>> 30;
            yy = (y * y) >>> 30; zz = (z * z) >>> 30;
            xy = (x * y) >>> 30; xz = (x * z) >>> 30;
            yz = (y * z) >>> 30; wx = (w * x) >>> 30;
            wy = (w * y) >>> 30; wz = (w * z) >>> 30;
            n = ww + xx + yy + zz;
            s = (64'sd1 <<< 61) / n;
            e[0] = longint'(ONE_Q30) - ((s * (yy + zz)) >>> 30);
            e[1] = (s * (xy - wz)) >>> 30;
            e[2] = (s * (xz + wy)) >>> 30;
            e[3] = (s * (xy + wz)) >>> 30;
            e[4] = longint'(ONE_Q30) - ((s * (xx + zz)) >>> 30);
            e[5] = (s * (yz - wx)) >>> 30;
            e[6] = (s * (xz - wy)) >>> 30;
            e[7] = (s * (yz + wx)) >>> 30;
            e[8] = longint'(ONE_Q30) - ((s * (xx + yy)) >>> 30);
            for (int i = 0; i < 9; i++)
                mat[i] = clamp(96'(e[i]), unused_hit);
        endfunction

        // Accepted vertex: fold it into the running extent.
        function void note_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                  bit last);
            logic signed [95:0] v [3];
            logic signed [95:0] acc, c;
            bit clip_now;
            bit hit;
            box_t b;
            if (!started)
            begin
                build_rotation();
                started = 1;
            end
            v[0] = 96'(signed'(vx));
            v[1] = 96'(signed'(vy));
            v[2] = 96'(signed'(vz));
            for (int i = 0; i < 3; i++)
            begin
                acc = mat[3*i] * v[0] + mat[3*i+1] * v[1] + mat[3*i+2] * v[2];
                c = ((acc + (96'sd1 <<< 29)) >>> 30) + 96'(pos[i]);
                hit = 0;
                c = clamp(c, hit);
                if (hit)
                    clip_seen = 1;
                if (c > run_upper[i])
                    run_upper[i] = c;
                if (c < run_lower[i])
                    run_lower[i] = c;
            end
            if (!last)
                return;
            clip_now = 0;
            for (int i = 0; i < 3; i++)
            begin
                b.upper[i] = 32'(clamp(run_upper[i] + MARGIN, clip_now));
                b.lower[i] = 32'(clamp(run_lower[i] - MARGIN, clip_now));
            end
            b.clipped = clip_seen | clip_now;
            b.bad_rotation = bad_seen;
            pending.push_back(b);
            clear_run();
        endfunction

        // Box beat from the core against the oldest prediction.
        function void check_box(logic [191:0] data, logic [1:0] user);
            box_t b;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected box beat %h user %b", $realtime, data, user);
                errors++;
                return;
            end
            b = pending.pop_front();
            for (int i = 0; i < 3; i++)
            begin
                if (data[32*i +: 32] !== b.upper[i])
                begin
                    $display("%0t: upper[%0d] expected %h actual %h", $realtime, i,
                             b.upper[i], data[32*i +: 32]);
                    errors++;
                end
                if (data[96 + 32*i +: 32] !== b.lower[i])
                begin
                    $display("%0t: lower[%0d] expected %h actual %h", $realtime, i,
                             b.lower[i], data[96 + 32*i +: 32]);
                    errors++;
                end
            end
            if (user[0] !== b.clipped)
            begin
                $display("%0t: clipped expected %b actual %b", $realtime, b.clipped, user[0]);
                errors++;
            end
            if (user[1] !== b.bad_rotation)
            begin
                $display("%0t: bad_rotation expected %b actual %b", $realtime,
                         b.bad_rotation, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;   // vertex_x, vertex_y, vertex_z
    logic         s_axis_tlast;   // last_vertex
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;   // upper_x/y/z, lower_x/y/z
    logic [1:0]   m_axis_tuser;   // clipped, bad_rotation
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    box_scoreboard boxes = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit recv_hold = 0;
    int idle_cycles = 0;

    transformed_point_bounding_box_core u_top (.*);

    // Clock.
    initial clk = 0;
    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial m_axis_tready = 0;
    always @(negedge clk)
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);

    // Box beat checker.
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            boxes.check_box(m_axis_tdata, m_axis_tuser);

    // Watchdog on cycles without any accepted beat or register write.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Register write over the configuration port.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        boxes.set_reg(idx, value);
    endtask

    // One vertex beat, held until accepted.
    task automatic send_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, bit last);
        if ($urandom_range(99) < send_idle_pct)
            repeat ($urandom_range(8, 30)) @(negedge clk);
        @(negedge clk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {vz, vy, vx};
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        boxes.note_vertex(vx, vy, vz, last);
        @(negedge clk);
        s_axis_tvalid <= 0;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'($urandom_range(2)) - 32'd1;
            3, 4:    return $urandom();
            5, 6:    return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
            default: return 32'($signed($urandom_range(1 << 29)) - (1 << 28));
        endcase
    endfunction

    function automatic logic [31:0] pick_quat();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'd0;
            3, 4:    return $urandom();
            default: return 32'($signed($urandom_range(1 << 31)) - (1 << 30));
        endcase
    endfunction

    // Run of random vertices, last one marked.
    task automatic send_run(int len);
        for (int i = 0; i < len; i++)
            send_vertex(pick_coord(), pick_coord(), pick_coord(), i == len - 1);
    endtask

    task automatic wait_drained();
        while (boxes.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_config();
        for (int i = 0; i < 3; i++)
            write_reg(3'(i), ($urandom_range(3) == 0) ? pick_coord() :
                             32'($signed($urandom_range(1 << 24)) - (1 << 23)));
        for (int i = 3; i < 7; i++)
            write_reg(3'(i), pick_quat());
    endtask

    initial
    begin
        int sent;
        bit hold_done;
        bit pause_done;
        hold_done = 0;
        pause_done = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tlast = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: reset identity, field extremes, clipping by margin.
        send_vertex(32'h0, 32'h0, 32'h0, 1);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 0);
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1);
        wait_drained();
        write_reg(REG_POS_X, 32'h7fff_0000);
        write_reg(REG_POS_Y, 32'h8000_0000);
        write_reg(REG_POS_Z, 32'h0001_0000);
        send_vertex(32'h4000_0000, 32'hc000_0000, 32'h7fff_ffff, 1);
        wait_drained();
        // Zero quaternion falls back to identity.
        write_reg(REG_QUAT_W, 32'h0);
        write_reg(REG_QUAT_X, 32'h0);
        write_reg(REG_QUAT_Y, 32'h0);
        write_reg(REG_QUAT_Z, 32'h0);
        send_vertex(32'h0001_0000, 32'hfffe_0000, 32'h0003_0000, 0);
        send_vertex(32'h5555_5555, 32'haaaa_aaaa, 32'h0, 1);
        wait_drained();
        // Quaternion extremes in w, x and y, with z at one.
        write_reg(REG_QUAT_W, 32'h8000_0000);
        write_reg(REG_QUAT_X, 32'h7fff_ffff);
        write_reg(REG_QUAT_Y, 32'h8000_0000);
        write_reg(REG_QUAT_Z, 32'h0000_0001);
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
        wait_drained();
        write_reg(REG_QUAT_W, 32'h0000_0001);
        write_reg(REG_QUAT_X, 32'h0);
        write_reg(REG_QUAT_Y, 32'h0);
        write_reg(REG_QUAT_Z, 32'hffff_ffff);
        send_vertex(32'h0010_0000, 32'hfff0_0000, 32'h0, 1);
        wait_drained();

        // Random phases under different stall patterns.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            random_config();
            sent = 0;
            while (sent < 420)
            begin
                int len;
                len = ($urandom_range(3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
                send_run(len);
                sent += len;
                if (phase == 0 && !hold_done && sent >= 100)
                begin
                    // Long receiver hold-off while single-vertex runs keep coming.
                    hold_done = 1;
                    fork
                        begin
                            recv_hold = 1;
                            repeat (600) @(posedge clk);
                            recv_hold = 0;
                        end
                    join_none
                    for (int k = 0; k < 12; k++)
                        send_run(1);
                    sent += 12;
                end
                if (phase == 1 && !pause_done && sent >= 200)
                begin
                    pause_done = 1;
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (boxes.errors == 0 && boxes.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* transformed_point_bounding_box_core.f */
hdl/tpbb_pkg.sv
hdl/tpbb_regs.sv
hdl/tpbb_mul.sv
hdl/tpbb_div.sv
hdl/transformed_point_bounding_box_core.sv
bench/transformed_point_bounding_box_core_test.sv
